// File: design/dem_sky_view_factor_core_defines.svh
// ---------------------------------------------------------------------------
// Sky view factor core: assertion macros
// Shared concurrent checks on the core clock with the active-low reset.
// ---------------------------------------------------------------------------
`ifndef DEM_SKY_VIEW_FACTOR_CORE_DEFINES_SVH
`define DEM_SKY_VIEW_FACTOR_CORE_DEFINES_SVH

// Same-cycle implication on clk_i, quiet while in reset.
`define DSVF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, quiet while in reset.
`define DSVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dsvf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sky view factor package
// Shared widths, codes, defaults and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package dsvf_pkg;

  // Default grid and look limits
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_COLS  = 256;
  localparam int DEF_MAX_LOOKS = 64;

  // Field widths
  localparam int ELEV_W = 24;
  localparam int RISE_W = 23;   // positive rise between two Q15.8 elevations
  localparam int SKY_W  = 17;   // Q1.16 factor, up to 1.0 inclusive
  localparam int DIV_W  = 32;   // numerator width of the shared divider

  // Operation codes on tuser
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_LOOK_COUNT = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_COL_COUNT  = 2'd2,
    CFG_CELL_SIZE  = 2'd3
  } cfg_idx_e;

  // Arctangent of 2^-k in 2^-16 turn
  function automatic logic [13:0] cordic_atan(input logic [3:0] k);
    logic [13:0] r;
    case (k)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/dem_sky_view_factor_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sky view factor core
// Holds an elevation grid in one synchronous RAM; loads write one cell,
// queries march look_count horizon rays and return the sky view factor.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 contents
//  s_axis    in   s_axis_tvalid/tready      tuser: operation; tdata: row, col, elevation
//  m_axis    out  m_axis_tvalid/tready      tdata: out_row, out_col, sky_view
//  cfg       in   cfg_we_i                  cfg_index_i, cfg_data_i
//
//  A load is a single RAM write. A query at or below zero elevation skips the rays.
//  Otherwise a query marches one ray per look until the ray leaves the grid;
//  each march step is one RAM read, one multiply stage and one compare, and
//  each direction adds a phase division, the CORDIC iterations, a scaling
//  loop and the 17-bit quotient loop of the term unit.
//  One item is in work at a time; s_axis_tready is high only while idle.
//  A finished result waits in the output register; the core holds in its
//  last state while that register is still full. Reset needs no RAM sweep.
// ---------------------------------------------------------------------------
`include "dem_sky_view_factor_core_defines.svh"

module dem_sky_view_factor_core #(
  parameter int MAX_ROWS  = dsvf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = dsvf_pkg::DEF_MAX_COLS,
  parameter int MAX_LOOKS = dsvf_pkg::DEF_MAX_LOOKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[7:0], col[15:8], elevation[39:16]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_row[7:0], out_col[15:8], sky_view[32:16]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import dsvf_pkg::*;

  localparam int MAXDIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIMW   = $clog2(MAXDIM + 1);
  localparam int PW     = DIMW + 18;
  localparam int DW     = DIMW + 17;
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CLW    = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int LW     = $clog2(MAX_LOOKS + 1);
  localparam int SUMW   = LW + SKY_W;
  localparam int PRW    = RISE_W + DW;
  localparam int XW     = 20;
  localparam int ZW     = 18;
  localparam int CSW    = 18;

  localparam logic signed [PW-1:0] UNIT   = PW'(65536);
  localparam logic signed [XW-1:0] XPOS   = XW'(65536);
  localparam logic signed [XW-1:0] XNEG   = -XW'(65536);
  localparam logic signed [XW-1:0] X_INIT = XW'(39797);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_BASE   = 12'b000000000010,
    S_NEXT   = 12'b000000000100,
    S_PHASE  = 12'b000000001000,
    S_CORDIC = 12'b000000010000,
    S_ROT    = 12'b000000100000,
    S_MARCH  = 12'b000001000000,
    S_WAIT   = 12'b000010000000,
    S_MUL    = 12'b000100000000,
    S_TERM   = 12'b001000000000,
    S_FINAL  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

  // Configuration registers
  logic [6:0]  look_q;
  logic [8:0]  rows_q;
  logic [8:0]  cols_q;
  logic [15:0] cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q <= 7'd8;
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      cell_q <= 16'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOOK_COUNT: look_q <= cfg_data_i[6:0];
        CFG_ROW_COUNT:  rows_q <= cfg_data_i[8:0];
        CFG_COL_COUNT:  cols_q <= cfg_data_i[8:0];
        CFG_CELL_SIZE:  cell_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective settings
  logic [LW-1:0]   looks;
  logic [DIMW-1:0] rows_sat;
  logic [DIMW-1:0] cols_sat;
  logic [15:0]     cell_len;
  logic signed [PW-1:0] ulim;
  logic signed [PW-1:0] vlim;

  always_comb begin
    if (look_q == '0) looks = LW'(1);
    else if (int'(look_q) > MAX_LOOKS) looks = LW'(MAX_LOOKS);
    else looks = LW'(look_q);
    rows_sat = (int'(rows_q) > MAX_ROWS) ? DIMW'(MAX_ROWS) : DIMW'(rows_q);
    cols_sat = (int'(cols_q) > MAX_COLS) ? DIMW'(MAX_COLS) : DIMW'(cols_q);
    cell_len = (cell_q == '0) ? 16'd1 : cell_q;
    ulim     = signed'(PW'({cols_sat, 16'h0000})) - UNIT;
    vlim     = signed'(PW'({rows_sat, 16'h0000})) - UNIT;
  end

  // State
  state_e                  state_q;
  logic [LW-1:0]           i_q;
  logic [SUMW-1:0]         sum_q;
  logic signed [ELEV_W-1:0] base_q;
  logic [1:0]              quad_q;
  logic signed [XW-1:0]    cx_q, cy_q;
  logic signed [ZW-1:0]    cz_q;
  logic [3:0]              ck_q;
  logic signed [CSW-1:0]   cs_q, sn_q;
  logic signed [PW-1:0]    u_q, v_q;
  logic [DW-1:0]           d_q, bd_q;
  logic [RISE_W-1:0]       bz_q;
  logic signed [ELEV_W:0]  rise_q;
  logic [PRW-1:0]          p1_q, p2_q;
  logic                    cmp_q;
  logic [7:0]              row_q, col_q;
  logic [SKY_W-1:0]        sky_q;
  logic                    ovalid_q;
  logic [7:0]              orow_q, ocol_q;
  logic [SKY_W-1:0]        osky_q;

  // Input decode
  logic       s_fire;
  logic [7:0] in_row, in_col;
  logic       in_inside;
  assign in_row    = s_axis_tdata[7:0];
  assign in_col    = s_axis_tdata[15:8];
  assign in_inside = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire    = s_axis_tvalid && s_axis_tready;

  // Elevation RAM
  logic [ELEV_W-1:0]        grid_mem [DEPTH];
  logic signed [ELEV_W-1:0] rd_q;
  logic [AW-1:0]            mem_addr;
  logic                     mem_we;
  logic signed [PW-1:0]     un, vn;

  assign un = u_q + PW'(cs_q);
  assign vn = v_q + PW'(sn_q);

  always_comb begin
    if (state_q == S_MARCH) begin
      mem_addr = AW'(vn[16 +: RW]) * AW'(MAX_COLS) + AW'(un[16 +: CLW]);
    end else begin
      mem_addr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
    end
  end
  assign mem_we = s_fire && (op_e'(s_axis_tuser[0]) == OP_LOAD) && in_inside;

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[mem_addr] <= s_axis_tdata[39:16];
    rd_q <= signed'(grid_mem[mem_addr]);
  end

  // Shared divider: phase of each look, then the final average
  logic            div_start;
  logic [DIV_W-1:0] div_num;
  logic            div_done;
  logic [DIV_W-1:0] div_quo;

  assign div_start = (state_q == S_NEXT);
  assign div_num   = (i_q == looks) ? (DIV_W'(sum_q) + DIV_W'(looks >> 1))
                                    : (DIV_W'({i_q, 16'h0000}) + DIV_W'(looks >> 1));

  dsvf_div #(
    .NW  (DIV_W),
    .DVW (LW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (looks),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Horizon compare, applied at the top of each march step
  logic              upd;
  logic [DW-1:0]     bd_n;
  logic [RISE_W-1:0] bz_n;
  logic              inside_ray;
  assign upd  = cmp_q && (p1_q > p2_q);
  assign bd_n = upd ? d_q : bd_q;
  assign bz_n = upd ? rise_q[RISE_W-1:0] : bz_q;
  assign inside_ray = (u_q > UNIT) && (u_q < ulim) && (v_q > UNIT) && (v_q < vlim);

  // Open-sky term unit
  logic             term_start;
  logic             term_done;
  logic [SKY_W-1:0] term_val;
  assign term_start = (state_q == S_MARCH) && !inside_ray;

  dsvf_term #(
    .DW (DW)
  ) u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (term_start),
    .dist_i  (bd_n),
    .rise_i  (bz_n),
    .done_o  (term_done),
    .term_o  (term_val)
  );

  // CORDIC step and final rotation
  logic signed [XW-1:0] xs, ys, cxc, cyc;
  logic signed [ZW-1:0] atan_z;
  assign xs     = cy_q >>> ck_q;
  assign ys     = cx_q >>> ck_q;
  assign atan_z = signed'(ZW'(cordic_atan(ck_q)));

  function automatic logic signed [XW-1:0] clamp_unit(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] r;
    if (x > XPOS) r = XPOS;
    else if (x < XNEG) r = XNEG;
    else r = x;
    return r;
  endfunction

  assign cxc = clamp_unit(cx_q);
  assign cyc = clamp_unit(cy_q);

  // Output register load
  logic out_load;
  assign out_load = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_fire && (op_e'(s_axis_tuser[0]) == OP_QUERY)) begin
            state_q <= in_inside ? S_BASE : S_OUT;
          end
        end
        S_BASE:   state_q <= (rd_q[ELEV_W-1] || rd_q == '0) ? S_OUT : S_NEXT;
        S_NEXT:   state_q <= (i_q == looks) ? S_FINAL : S_PHASE;
        S_PHASE:  if (div_done) state_q <= S_CORDIC;
        S_CORDIC: if (ck_q == 4'd15) state_q <= S_ROT;
        S_ROT:    state_q <= S_MARCH;
        S_MARCH:  state_q <= inside_ray ? S_WAIT : S_TERM;
        S_WAIT:   state_q <= S_MUL;
        S_MUL:    state_q <= S_MARCH;
        S_TERM:   if (term_done) state_q <= S_NEXT;
        S_FINAL:  if (div_done) state_q <= S_OUT;
        S_OUT:    if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        row_q <= in_row;
        col_q <= in_col;
        sky_q <= '0;
      end
      S_BASE: begin
        base_q <= rd_q;
        i_q    <= '0;
        sum_q  <= '0;
      end
      S_PHASE: begin
        quad_q <= div_quo[15:14];
        cx_q   <= X_INIT;
        cy_q   <= '0;
        cz_q   <= signed'(ZW'(div_quo[13:0]));
        ck_q   <= '0;
      end
      S_CORDIC: begin
        if (!cz_q[ZW-1]) begin
          cx_q <= cx_q - xs;
          cy_q <= cy_q + ys;
          cz_q <= cz_q - atan_z;
        end else begin
          cx_q <= cx_q + xs;
          cy_q <= cy_q - ys;
          cz_q <= cz_q + atan_z;
        end
        ck_q <= ck_q + 1'b1;
      end
      S_ROT: begin
        case (quad_q)
          2'd0: begin cs_q <= CSW'(cxc);  sn_q <= CSW'(cyc);  end
          2'd1: begin cs_q <= -CSW'(cyc); sn_q <= CSW'(cxc);  end
          2'd2: begin cs_q <= -CSW'(cxc); sn_q <= -CSW'(cyc); end
          default: begin cs_q <= CSW'(cyc); sn_q <= -CSW'(cxc); end
        endcase
        u_q   <= signed'(PW'({col_q, 16'h8000}));
        v_q   <= signed'(PW'({row_q, 16'h8000}));
        d_q   <= '0;
        bd_q  <= DW'(1);
        bz_q  <= '0;
        cmp_q <= 1'b0;
      end
      S_MARCH: begin
        bd_q  <= bd_n;
        bz_q  <= bz_n;
        cmp_q <= 1'b0;
        if (inside_ray) begin
          u_q <= un;
          v_q <= vn;
          d_q <= d_q + DW'(cell_len);
        end
      end
      S_WAIT: rise_q <= (ELEV_W + 1)'(rd_q) - (ELEV_W + 1)'(base_q);
      S_MUL: begin
        p1_q  <= PRW'(rise_q[RISE_W-1:0]) * PRW'(bd_q);
        p2_q  <= PRW'(bz_q) * PRW'(d_q);
        cmp_q <= (rise_q > 0);
      end
      S_TERM: begin
        if (term_done) begin
          sum_q <= sum_q + SUMW'(term_val);
          i_q   <= i_q + 1'b1;
        end
      end
      S_FINAL: if (div_done) sky_q <= div_quo[SKY_W-1:0];
      S_OUT: begin
        if (out_load) begin
          orow_q <= row_q;
          ocol_q <= col_q;
          osky_q <= sky_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'b0, osky_q, ocol_q, orow_q};

  // Checks
  `DSVF_ASSERT_IMPL(a_out_from_out, $rose(m_axis_tvalid), $past(state_q == S_OUT), "stray result")
  `DSVF_ASSERT_IMPL(a_term_in_term, term_done, state_q == S_TERM, "term done outside term wait")
  `DSVF_ASSERT_IMPL(a_div_owner, div_done, state_q == S_PHASE || state_q == S_FINAL, "divider idle")
  `DSVF_ASSERT_NEXT(a_cordic_len, state_q == S_CORDIC && ck_q == 4'd15, state_q == S_ROT, "CORDIC overrun")

endmodule

// File: design/dsvf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module dsvf_div #(
  parameter int NW  = dsvf_pkg::DIV_W,
  parameter int DVW = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  output logic           done_o,
  output logic [NW-1:0]  quo_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    n_q;
  logic [DVW-1:0]   rem_q;
  logic [DVW-1:0]   den_q;
  logic             done_q;
  logic [DVW:0]     trial;
  logic             ge;

  // Trial subtract of the divisor from the partial remainder
  assign trial = {rem_q, n_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], ge};
      rem_q <= ge ? DVW'(trial - {1'b0, den_q}) : DVW'(trial);
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

// File: design/dsvf_term.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Open-sky term unit
// Computes round(a^2 * 2^16 / (a^2 + b^2)) for one direction's horizon,
// with a = distance * 256 and b = rise, both scaled down below 2^23.
// ---------------------------------------------------------------------------
module dsvf_term #(
  parameter int DW = 26
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dist_i,
  input  logic [dsvf_pkg::RISE_W-1:0]  rise_i,
  output logic                         done_o,
  output logic [dsvf_pkg::SKY_W-1:0]   term_o
);
  import dsvf_pkg::*;

  localparam int AW  = DW + 8;
  localparam int SQW = 2 * RISE_W;
  localparam int RMW = 64;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_NORM = 5'b00010,
    T_SQ   = 5'b00100,
    T_DEN  = 5'b01000,
    T_DIV  = 5'b10000
  } term_state_e;

  term_state_e       state_q;
  logic [AW-1:0]     a_q;
  logic [RISE_W-1:0] b_q;
  logic [SQW-1:0]    aa_q;
  logic [SQW-1:0]    bb_q;
  logic [RMW-1:0]    rem_q;
  logic [RMW-1:0]    dsh_q;
  logic [4:0]        j_q;
  logic [SKY_W-1:0]  q_q;
  logic              done_q;
  logic [SQW:0]      den;
  logic              ge;

  assign den = {1'b0, aa_q} + {1'b0, bb_q};
  assign ge  = rem_q >= dsh_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        T_IDLE: if (start_i) state_q <= T_NORM;
        T_NORM: if (a_q[AW-1:RISE_W] == '0) state_q <= T_SQ;
        T_SQ:   state_q <= T_DEN;
        T_DEN: begin
          j_q     <= 5'd16;
          state_q <= T_DIV;
        end
        T_DIV: begin
          j_q <= j_q - 1'b1;
          if (j_q == '0) begin
            done_q  <= 1'b1;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // Datapath: scale, square, then one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        a_q <= {dist_i, 8'h00};
        b_q <= rise_i;
      end
      T_NORM: begin
        if (a_q[AW-1:RISE_W] != '0) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
        end
      end
      T_SQ: begin
        aa_q <= SQW'(a_q[RISE_W-1:0]) * SQW'(a_q[RISE_W-1:0]);
        bb_q <= SQW'(b_q) * SQW'(b_q);
      end
      T_DEN: begin
        rem_q <= RMW'({aa_q, 16'h0000}) + RMW'(den >> 1);
        dsh_q <= RMW'({den, 16'h0000});
        q_q   <= '0;
      end
      T_DIV: begin
        if (ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= {q_q[SKY_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign term_o = q_q;

endmodule
